[rtl/assert_macros.svh]
// Assertion macros for the block table allocator checkers.
// No dependencies; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with synchronous active-low reset as disable.
`define BTFF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same, on the default clock and reset names i_clk and i_rst_n.
`define BTFF_ASSERT_CHK(lbl, prop, msg) \
    `BTFF_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

[rtl/btff_pkg.sv]
// Package for the block table first-fit allocator: payload types, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps

package btff_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int BLOCK_BYTES_DEF   = 4096;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int BIU_W      = 11;
    localparam int BIU_RESET  = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 4'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int FLAG_W = 3;
    localparam logic [FLAG_W-1:0] FLAG_TAKEN = 3'b001;
    localparam logic [FLAG_W-1:0] FLAG_FIRST = 3'b010;
    localparam logic [FLAG_W-1:0] FLAG_NEXT  = 3'b100;
    localparam int FLAG_TAKEN_BIT = 0;
    localparam int FLAG_NEXT_BIT  = 2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic        opcode;
        logic [31:0] request_bytes;
        logic [31:0] release_address;
    } t_in;

    typedef struct packed {
        logic [31:0] granted_address;
        t_status     status;
    } t_out;

endpackage

[rtl/block_table_first_fit_allocator.sv]
// First-fit block table allocator, top level. Depends on btff_pkg, btff_table, btff_div.
// Allocate: the divider sizes the request, a scan reads one entry per cycle up to the
// span, each granted block is marked in turn, and the address is formed last.
// Free: the divider indexes the entry, then each chained entry is read and cleared.
// One request in flight; the next is taken while the previous result waits.
// After reset a clearing pass writes every entry before the first request is taken.
`timescale 1ns / 1ps

module block_table_first_fit_allocator #(
    parameter int TABLE_ENTRIES = btff_pkg::TABLE_ENTRIES_DEF,
    parameter int BLOCK_BYTES   = btff_pkg::BLOCK_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  btff_pkg::t_in                  i_in_data,
    output logic                           o_in_ready,
    output logic                           o_out_valid,
    output btff_pkg::t_out                 o_out_data,
    input  logic                           i_out_ready,
    input  logic                           i_cfg_valid,
    input  logic [btff_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [btff_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_cfg_ready
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int SPAN_W = $clog2(TABLE_ENTRIES + 1);
    localparam int BIU_W  = btff_pkg::BIU_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_MARK,
        S_MUL,
        S_ADDR,
        S_FREE,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_op, n_op;
    btff_pkg::t_status      r_res_st, n_res_st;
    logic [31:0]            r_res_addr, n_res_addr;
    logic [SPAN_W-1:0]      r_need, n_need;
    logic [SPAN_W-1:0]      r_run, n_run;
    logic [IDX_W-1:0]       r_first, n_first;
    logic [SPAN_W-1:0]      r_rd_idx, n_rd_idx;
    logic                   r_pend, n_pend;
    logic [IDX_W-1:0]       r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]       r_wr_idx, n_wr_idx;
    logic [SPAN_W-1:0]      r_left, n_left;
    logic [31:0]            r_prod, n_prod;
    logic                   r_out_valid, n_out_valid;
    btff_pkg::t_out         r_out, n_out;
    logic [31:0]            r_heap_base;
    logic [BIU_W-1:0]       r_biu;

    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [btff_pkg::FLAG_W-1:0] w_wdata;
    logic                   w_re;
    logic [IDX_W-1:0]       w_raddr;
    logic [btff_pkg::FLAG_W-1:0] w_rdata;

    logic                   w_div_start;
    logic [32:0]            w_div_dividend;
    logic                   w_div_done;
    logic [32:0]            w_quot;

    logic [SPAN_W-1:0]      w_span;
    logic [SPAN_W-1:0]      w_run_inc;
    logic [SPAN_W-1:0]      w_pend_next;
    logic [63:0]            w_prod;

    btff_table #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    btff_div #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        if (32'(r_biu) > 32'(TABLE_ENTRIES)) begin
            w_span = SPAN_W'(TABLE_ENTRIES);
        end else begin
            w_span = SPAN_W'(r_biu);
        end
    end

    assign w_run_inc   = r_run + SPAN_W'(1);
    assign w_pend_next = SPAN_W'(r_pend_idx) + SPAN_W'(1);
    assign w_prod      = 64'(r_first) * 64'(BLOCK_BYTES);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_res_st    = r_res_st;
        n_res_addr  = r_res_addr;
        n_need      = r_need;
        n_run       = r_run;
        n_first     = r_first;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_wr_idx    = r_wr_idx;
        n_left      = r_left;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        w_we    = 1'b0;
        w_waddr = r_wr_idx;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = r_rd_idx[IDX_W-1:0];

        w_div_start    = 1'b0;
        w_div_dividend = 33'(i_in_data.request_bytes) + 33'(BLOCK_BYTES - 1);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_we     = 1'b1;
                w_waddr  = r_wr_idx;
                n_wr_idx = r_wr_idx + 1'b1;
                if (r_wr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_in_data.opcode;
                    n_res_addr = '0;
                    if (i_in_data.opcode == btff_pkg::OP_ALLOC) begin
                        if (i_in_data.request_bytes == 32'd0) begin
                            n_res_st = btff_pkg::ST_INVALID;
                            n_state  = S_DONE;
                        end else begin
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end else begin
                        if (i_in_data.release_address < r_heap_base) begin
                            n_res_st = btff_pkg::ST_INVALID;
                            n_state  = S_DONE;
                        end else begin
                            w_div_dividend =
                                33'(i_in_data.release_address - r_heap_base);
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_pend = 1'b0;
                    if (r_op == btff_pkg::OP_ALLOC) begin
                        if (w_quot > 33'(w_span)) begin
                            n_res_st = btff_pkg::ST_NOMEM;
                            n_state  = S_DONE;
                        end else begin
                            n_need   = w_quot[SPAN_W-1:0];
                            n_run    = '0;
                            n_rd_idx = '0;
                            n_state  = S_SCAN;
                        end
                    end else begin
                        if (w_quot >= 33'(w_span)) begin
                            n_res_st = btff_pkg::ST_INVALID;
                            n_state  = S_DONE;
                        end else begin
                            n_rd_idx = w_quot[SPAN_W-1:0];
                            n_state  = S_FREE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_idx < w_span) begin
                    w_re       = 1'b1;
                    w_raddr    = r_rd_idx[IDX_W-1:0];
                    n_rd_idx   = r_rd_idx + 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (w_rdata[btff_pkg::FLAG_TAKEN_BIT]) begin
                        n_run = '0;
                    end else begin
                        if (r_run == '0) begin
                            n_first = r_pend_idx;
                        end
                        n_run = w_run_inc;
                        if (w_run_inc == r_need) begin
                            n_wr_idx = (r_run == '0) ? r_pend_idx : r_first;
                            n_left   = r_need;
                            n_pend   = 1'b0;
                            n_state  = S_MARK;
                        end
                    end
                end else if (r_rd_idx >= w_span) begin
                    n_res_st = btff_pkg::ST_NOMEM;
                    n_state  = S_DONE;
                end
            end
            S_MARK: begin
                w_we    = 1'b1;
                w_waddr = r_wr_idx;
                w_wdata = btff_pkg::FLAG_TAKEN
                        | ((r_wr_idx == r_first) ? btff_pkg::FLAG_FIRST : '0)
                        | ((r_left != SPAN_W'(1)) ? btff_pkg::FLAG_NEXT : '0);
                n_wr_idx = r_wr_idx + 1'b1;
                n_left   = r_left - 1'b1;
                if (r_left == SPAN_W'(1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = w_prod[31:0];
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_res_addr = r_heap_base + r_prod;
                n_res_st   = btff_pkg::ST_OK;
                n_state    = S_DONE;
            end
            S_FREE: begin
                if (!r_pend) begin
                    w_re       = 1'b1;
                    w_raddr    = r_rd_idx[IDX_W-1:0];
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[IDX_W-1:0];
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_pend_idx;
                    w_wdata = '0;
                    if (w_rdata[btff_pkg::FLAG_NEXT_BIT] && (w_pend_next < w_span)) begin
                        w_re       = 1'b1;
                        w_raddr    = w_pend_next[IDX_W-1:0];
                        n_pend_idx = w_pend_next[IDX_W-1:0];
                    end else begin
                        n_pend   = 1'b0;
                        n_res_st = btff_pkg::ST_OK;
                        n_state  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_out.granted_address = r_res_addr;
                    n_out.status          = r_res_st;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wr_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_heap_base <= '0;
            r_biu       <= BIU_W'(btff_pkg::BIU_RESET);
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    btff_pkg::CFG_HEAP_BASE: begin
                        r_heap_base <= i_cfg_data;
                    end
                    btff_pkg::CFG_BLOCKS_IN_USE: begin
                        r_biu <= i_cfg_data[BIU_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        r_op       <= n_op;
        r_res_st   <= n_res_st;
        r_res_addr <= n_res_addr;
        r_need     <= n_need;
        r_run      <= n_run;
        r_first    <= n_first;
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_left     <= n_left;
        r_prod     <= n_prod;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    // register writes only between requests
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;

endmodule

[rtl/btff_table.sv]
// Block flag table: one write port, one read port, registered read data.
// Depends on btff_pkg.
`timescale 1ns / 1ps

module btff_table #(
    parameter int DEPTH  = btff_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [btff_pkg::FLAG_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [btff_pkg::FLAG_W-1:0] o_rdata
);

    logic [btff_pkg::FLAG_W-1:0] r_mem [DEPTH];
    logic [btff_pkg::FLAG_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/btff_div.sv]
// Block size divider: a registered right shift by log2 of the block size, which is a power
// of two. Depends on btff_pkg for the default divisor.
`timescale 1ns / 1ps

module btff_div #(
    parameter int DIVISOR = btff_pkg::BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    output logic        o_done,
    output logic [32:0] o_quotient
);

    localparam int SH = $clog2(DIVISOR);

    logic [32:0] r_quot;
    logic        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        if (i_start) begin
            r_quot <= i_dividend >> SH;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

[rtl/btff_checker.sv]
// Port-level checker for the block table allocator, bound to the top level.
// Depends on btff_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module btff_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input btff_pkg::t_out o_out_data,
    input logic           i_out_ready
);

    `BTFF_ASSERT_CHK(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)), "result changed or dropped before transfer")
    `BTFF_ASSERT_CHK(a_out_drop, $fell(o_out_valid) |-> $past(i_out_ready), "result valid fell without a transfer")
    `BTFF_ASSERT_CHK(a_fail_addr, (o_out_valid && (o_out_data.status != btff_pkg::ST_OK) && (o_out_data.status != btff_pkg::ST_NOMEM)) |-> (o_out_data.granted_address == 32'd0), "invalid request carries an address")
    `BTFF_ASSERT_CHK(a_one_item, (i_in_valid && o_in_ready) |=> !o_in_ready, "second request taken while one is in flight")

endmodule

bind block_table_first_fit_allocator btff_checker u_btff_checker (.*);
